// File: hw/rtl/box_blur_3x3_stream_macros.svh
// Assertion macros for the streaming 3x3 box filter.
// Included by the RTL files that carry concurrent checks; expects clk and rst in scope.
// Each macro is empty when SYNTH is defined.
`ifndef BOX_BLUR_3X3_STREAM_MACROS_SVH
`define BOX_BLUR_3X3_STREAM_MACROS_SVH
`ifndef SYNTH
`define BB_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("box_blur_3x3_stream: check failed");
`define BB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box_blur_3x3_stream: check failed");
`define BB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("box_blur_3x3_stream: check failed");
`else
`define BB_ASSERT(lbl, expr)
`define BB_ASSERT_IMP(lbl, ante, cons)
`define BB_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/bblur_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the streaming 3x3 box filter.
// No dependencies; used by the line store and the top level.
package bblur_pkg;

  localparam int unsigned MAX_WIDTH_DEF    = 2048;
  localparam int unsigned MAX_CHANNELS_DEF = 4;

  localparam int unsigned SAMPLE_W     = 8;
  localparam int unsigned ROW_W        = 16;
  localparam int unsigned OUT_COL_W    = 11;
  localparam int unsigned OUT_CHAN_W   = 2;
  localparam int unsigned COLSUM_W     = 10;
  localparam int unsigned TOTAL_W      = 12;
  localparam int unsigned PRODUCT_W    = 25;

  localparam int unsigned CFG_INDEX_W  = 2;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CFG_WIDTH_W  = 12;
  localparam int unsigned CFG_HEIGHT_W = 16;
  localparam int unsigned CFG_CHAN_W   = 3;

  localparam int unsigned RESET_WIDTH    = 640;
  localparam int unsigned RESET_HEIGHT   = 480;
  localparam int unsigned RESET_CHANNELS = 3;

  // floor(t / 9) == (t * 7282) >> 16 for every window total up to 9 * 255.
  localparam int unsigned DIV9_RECIP = 7282;
  localparam int unsigned DIV9_SHIFT = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LINE_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } cfg_reg_t;

  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [OUT_COL_W-1:0]  col_out_t;
  typedef logic [OUT_CHAN_W-1:0] chan_out_t;
  typedef logic [COLSUM_W-1:0]   colsum_t;
  typedef logic [TOTAL_W-1:0]    total_t;
  typedef logic [PRODUCT_W-1:0]  product_t;

  // One line store entry: the same column and channel on the two previous rows.
  typedef struct packed {
    sample_t above;
    sample_t two_above;
  } line_pair_t;

endpackage

// File: hw/rtl/bblur_line_mem.sv
`timescale 1ns / 1ps
// Line store of the 3x3 box filter: one entry per column and channel, holding two rows.
// Depends on bblur_pkg for the entry type.
module bblur_line_mem #(
  parameter int unsigned DEPTH = bblur_pkg::MAX_WIDTH_DEF * bblur_pkg::MAX_CHANNELS_DEF,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [ADDR_W-1:0]      rd_addr,
  output bblur_pkg::line_pair_t  rd_data,
  input  logic                   wr_en,
  input  logic [ADDR_W-1:0]      wr_addr,
  input  bblur_pkg::line_pair_t  wr_data
);

  bblur_pkg::line_pair_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds while rd_en is low, so a stalled item keeps its operands.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/box_blur_3x3_stream.sv
`timescale 1ns / 1ps
// Top level of the streaming 3x3 box filter (truncated mean over each channel's window).
// Depends on bblur_pkg, bblur_line_mem and box_blur_3x3_stream_macros.svh.
//
// Usage: samples enter one per item on the in channel in raster order, channels of a
// pixel interleaved. For every sample that completes a window whose centre is an
// interior pixel, one item leaves on the out channel with the mean, the centre's
// column and row, the channel, and frame_last on the final interior result of a frame.
// Border samples update the line store and column sums but produce no item.
// The cfg channel writes the row width in pixels, the frame height in rows and the
// channel count (index 0, 1, 2); it is always ready, and a write to any of the three
// restarts the frame at row 0. Out-of-range values are clamped when written.
// Configure only while the block is idle.
// Throughput is one item per cycle while out_ready is high: the line store is read when
// an item is accepted and written back as it leaves stage 1, and a column revisits the same
// entry only a full row on. From the accepting edge a result passes through three
// registers: line store read, window sum, divide by nine by a reciprocal multiply.
// When the receiver stalls, the pipeline stages fill and in_ready drops; items that give
// no result still drain while the output waits. Reset empties the pipeline, zeroes the
// counters and column sums, and loads 640 x 480 with three channels. The line store needs
// no clearing: its contents are used only from row 2 on, at entries this frame already wrote.
module box_blur_3x3_stream #(
  parameter int unsigned MAX_WIDTH    = bblur_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_CHANNELS = bblur_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bblur_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bblur_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  bblur_pkg::sample_t                   sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output bblur_pkg::sample_t                   blurred,
  output bblur_pkg::col_out_t                  out_column,
  output bblur_pkg::row_t                      out_row,
  output bblur_pkg::chan_out_t                 out_channel,
  output logic                                 frame_last
);

`include "box_blur_3x3_stream_macros.svh"

  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned CHI_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CS_DEPTH   = 1 << CHI_W;
  localparam int unsigned LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned LINE_AW    = $clog2(LINE_DEPTH);

  localparam int unsigned RESET_LAST_COL =
    ((bblur_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : bblur_pkg::RESET_WIDTH) - 1;
  localparam int unsigned RESET_LAST_CHAN =
    ((bblur_pkg::RESET_CHANNELS > MAX_CHANNELS) ? MAX_CHANNELS
                                                : bblur_pkg::RESET_CHANNELS) - 1;

  // Configuration, kept as the last valid column, row and channel.
  logic [COL_W-1:0]   last_col;
  bblur_pkg::row_t    last_row;
  logic [CHI_W-1:0]   last_chan;

  logic [bblur_pkg::CFG_WIDTH_W-1:0]  cfg_width;
  logic [bblur_pkg::CFG_HEIGHT_W-1:0] cfg_height;
  logic [bblur_pkg::CFG_CHAN_W-1:0]   cfg_chan;
  logic [COL_W-1:0]   last_col_next;
  bblur_pkg::row_t    last_row_next;
  logic [CHI_W-1:0]   last_chan_next;
  logic               cfg_write;
  logic               cfg_restart;

  // Position of the next sample and its line store address.
  logic [COL_W-1:0]   col_count, col_count_next;
  bblur_pkg::row_t    row_count, row_count_next;
  logic [CHI_W-1:0]   chan_count, chan_count_next;
  logic [LINE_AW-1:0] line_idx, line_idx_next;
  logic               row_end;
  logic               frame_end;

  // Handshake of the three pipeline registers.
  logic in_accept;
  logic s1_valid, s1_adv;
  logic s2_valid, s2_adv, s2_free;
  logic out_free;

  // Stage 1: accepted sample, with the line store entry read alongside it.
  bblur_pkg::sample_t    s1_sample;
  logic [CHI_W-1:0]      s1_chan;
  logic [COL_W-1:0]      s1_colm1;
  bblur_pkg::row_t       s1_rowm1;
  logic [LINE_AW-1:0]    s1_idx;
  logic                  s1_row_ge2;
  logic                  s1_result;
  logic                  s1_last;
  bblur_pkg::line_pair_t line_rd;
  bblur_pkg::line_pair_t line_wr;
  bblur_pkg::colsum_t    colsum;
  bblur_pkg::total_t     total;

  bblur_pkg::colsum_t    col_sum0 [CS_DEPTH];
  bblur_pkg::colsum_t    col_sum1 [CS_DEPTH];

  // Stage 2: window total waiting for the divide.
  bblur_pkg::total_t     s2_total;
  logic [COL_W-1:0]      s2_colm1;
  bblur_pkg::row_t       s2_rowm1;
  logic [CHI_W-1:0]      s2_chan;
  logic                  s2_last;
  bblur_pkg::product_t   product;

  // ---------------------------------------------------------------- configuration

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_width  = cfg_data[bblur_pkg::CFG_WIDTH_W-1:0];
  assign cfg_height = cfg_data[bblur_pkg::CFG_HEIGHT_W-1:0];
  assign cfg_chan   = cfg_data[bblur_pkg::CFG_CHAN_W-1:0];

  assign cfg_restart = cfg_write &&
                       (cfg_index == bblur_pkg::REG_LINE_WIDTH ||
                        cfg_index == bblur_pkg::REG_FRAME_HEIGHT ||
                        cfg_index == bblur_pkg::REG_CHANNEL_COUNT);

  // Clamp each register to the range the datapath supports as it is written.
  always_comb begin
    if (cfg_width < 12'd3) begin
      last_col_next = COL_W'(2);
    end else if (32'(cfg_width) > MAX_WIDTH) begin
      last_col_next = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col_next = COL_W'(cfg_width - 12'd1);
    end

    if (cfg_height < 16'd3) begin
      last_row_next = 16'd2;
    end else begin
      last_row_next = cfg_height - 16'd1;
    end

    if (cfg_chan == 3'd0) begin
      last_chan_next = '0;
    end else if (32'(cfg_chan) > MAX_CHANNELS) begin
      last_chan_next = CHI_W'(MAX_CHANNELS - 1);
    end else begin
      last_chan_next = CHI_W'(cfg_chan - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_col  <= COL_W'(RESET_LAST_COL);
      last_row  <= bblur_pkg::row_t'(bblur_pkg::RESET_HEIGHT - 1);
      last_chan <= CHI_W'(RESET_LAST_CHAN);
    end else if (cfg_write) begin
      case (cfg_index)
        bblur_pkg::REG_LINE_WIDTH:    last_col  <= last_col_next;
        bblur_pkg::REG_FRAME_HEIGHT:  last_row  <= last_row_next;
        bblur_pkg::REG_CHANNEL_COUNT: last_chan <= last_chan_next;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- flow control

  // An item with no result leaves stage 1 without needing room further on.
  assign out_free  = !out_valid || out_ready;
  assign s2_adv    = s2_valid && out_free;
  assign s2_free   = !s2_valid || s2_adv;
  assign s1_adv    = s1_valid && (!s1_result || s2_free);
  assign in_ready  = !s1_valid || s1_adv;
  assign in_accept = in_valid && in_ready;

  // ---------------------------------------------------------------- position counters

  assign row_end   = (chan_count == last_chan) && (col_count == last_col);
  assign frame_end = row_end && (row_count == last_row);

  always_comb begin
    col_count_next  = col_count;
    row_count_next  = row_count;
    chan_count_next = chan_count;
    line_idx_next   = line_idx;
    if (in_accept) begin
      if (row_end) begin
        line_idx_next = '0;
      end else begin
        line_idx_next = line_idx + LINE_AW'(1);
      end
      if (chan_count == last_chan) begin
        chan_count_next = '0;
        if (col_count == last_col) begin
          col_count_next = '0;
          row_count_next = (row_count == last_row) ? '0 : row_count + 16'd1;
        end else begin
          col_count_next = col_count + COL_W'(1);
        end
      end else begin
        chan_count_next = chan_count + CHI_W'(1);
      end
    end
    if (cfg_restart) begin
      col_count_next  = '0;
      row_count_next  = '0;
      chan_count_next = '0;
      line_idx_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      chan_count <= '0;
      line_idx   <= '0;
    end else begin
      col_count  <= col_count_next;
      row_count  <= row_count_next;
      chan_count <= chan_count_next;
      line_idx   <= line_idx_next;
    end
  end

  // ---------------------------------------------------------------- stage 1

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_sample  <= sample;
      s1_chan    <= chan_count;
      s1_colm1   <= col_count - COL_W'(1);
      s1_rowm1   <= row_count - 16'd1;
      s1_idx     <= line_idx;
      s1_row_ge2 <= (row_count >= 16'd2);
      s1_result  <= (row_count >= 16'd2) && (col_count >= COL_W'(2));
      s1_last    <= frame_end;
    end
  end

  bblur_line_mem #(
    .DEPTH (LINE_DEPTH)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (line_idx),
    .rd_data (line_rd),
    .wr_en   (s1_adv),
    .wr_addr (s1_idx),
    .wr_data (line_wr)
  );

  // The entry shifts down one row: the current sample becomes the row above.
  assign line_wr.above     = s1_sample;
  assign line_wr.two_above = line_rd.above;

  // On the first two rows the column sum is the sample alone.
  always_comb begin
    if (s1_row_ge2) begin
      colsum = bblur_pkg::colsum_t'(line_rd.two_above) +
               bblur_pkg::colsum_t'(line_rd.above) +
               bblur_pkg::colsum_t'(s1_sample);
    end else begin
      colsum = bblur_pkg::colsum_t'(s1_sample);
    end
    total = bblur_pkg::total_t'(colsum) +
            bblur_pkg::total_t'(col_sum0[s1_chan]) +
            bblur_pkg::total_t'(col_sum1[s1_chan]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CS_DEPTH; i++) begin
        col_sum0[i] <= '0;
        col_sum1[i] <= '0;
      end
    end else if (s1_adv) begin
      col_sum1[s1_chan] <= col_sum0[s1_chan];
      col_sum0[s1_chan] <= colsum;
    end
  end

  // ---------------------------------------------------------------- stage 2

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv && s1_result) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_result) begin
      s2_total <= total;
      s2_colm1 <= s1_colm1;
      s2_rowm1 <= s1_rowm1;
      s2_chan  <= s1_chan;
      s2_last  <= s1_last;
    end
  end

  assign product = bblur_pkg::product_t'(s2_total) *
                   bblur_pkg::product_t'(bblur_pkg::DIV9_RECIP);

  // ---------------------------------------------------------------- output register

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      blurred     <= product[bblur_pkg::DIV9_SHIFT +: bblur_pkg::SAMPLE_W];
      out_column  <= bblur_pkg::col_out_t'(s2_colm1);
      out_row     <= s2_rowm1;
      out_channel <= bblur_pkg::chan_out_t'(s2_chan);
      frame_last  <= s2_last;
    end
  end

  // ---------------------------------------------------------------- checks

  `BB_ASSERT(a_pos_in_range, col_count <= last_col && chan_count <= last_chan && row_count <= last_row)
  `BB_ASSERT_IMP(a_row_start_idx, col_count == '0 && chan_count == '0, line_idx == '0)
  `BB_ASSERT_NEXT(a_frame_wrap, in_accept && frame_end, row_count == '0 && col_count == '0 && chan_count == '0)
  `BB_ASSERT_NEXT(a_s1_hold, s1_valid && !s1_adv, s1_valid && $stable(s1_idx) && $stable(line_rd))
  `BB_ASSERT_IMP(a_out_interior, out_valid, out_row != '0)

endmodule
